// ===== rtl/assert_macros.svh =====
// Assertion helpers for the curve evaluator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bcpe_pkg.sv =====
package bcpe_pkg;
  localparam int MaxPointsDef = 16;
  localparam int CoordW = 32;
  localparam int RatioW = 17;
  localparam int CountW = 5;
  localparam int FracW = 16;
  localparam logic [RatioW-1:0] RatioOne = 17'h10000;
  localparam logic [CountW-1:0] CountReset = 5'd4;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_EVAL = 1'b1} cmd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_FILL, ST_RUN, ST_OUT} state_t;

  // Control sent down the cell row each cycle
  typedef struct packed {
    logic load;   // parallel load from the point store
    logic shift;  // one lerp pass step
  } cell_ctl_t;
endpackage

// ===== rtl/bcpe_if.sv =====
interface bcpe_in_if;
  import bcpe_pkg::*;
  logic valid;
  logic ready;
  logic command;
  logic [3:0] point_index;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;
  logic [RatioW-1:0] ratio;
  modport source (output valid, command, point_index, in_x, in_y, in_z, ratio,
                  input ready);
  modport sink (input valid, command, point_index, in_x, in_y, in_z, ratio,
                output ready);
endinterface

interface bcpe_out_if;
  import bcpe_pkg::*;
  logic valid;
  logic ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

interface bcpe_cfg_if;
  import bcpe_pkg::*;
  logic valid;
  logic ready;
  logic [CountW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/bcpe_lerp.sv =====
// One lerp on one axis: a + floor(t*(b-a) / 2^16)
module bcpe_lerp
  import bcpe_pkg::*;
(
  input  coord_t            a,
  input  coord_t            b,
  input  logic [RatioW-1:0] t,
  output coord_t            y
);
  logic signed [CoordW:0]          diff;
  logic signed [CoordW+RatioW+1:0] prod;
  logic signed [CoordW+RatioW+1:0] sum;

  always_comb begin
    diff = {b[CoordW-1], b} - {a[CoordW-1], a};
    prod = diff * $signed({1'b0, t});
    sum  = {{(RatioW+2){a[CoordW-1]}}, a} + (prod >>> FracW);
    y    = sum[CoordW-1:0];
  end
endmodule

// ===== rtl/bcpe_cell.sv =====
// One cell of the reduction row: holds a point, lerps toward its right neighbor
module bcpe_cell
  import bcpe_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  point_t            load_pt,
  input  point_t            right_pt,
  input  logic [RatioW-1:0] t,
  output point_t            pt
);
  point_t lerp_pt;

  bcpe_lerp u_lx (.a(pt.x), .b(right_pt.x), .t(t), .y(lerp_pt.x));
  bcpe_lerp u_ly (.a(pt.y), .b(right_pt.y), .t(t), .y(lerp_pt.y));
  bcpe_lerp u_lz (.a(pt.z), .b(right_pt.z), .t(t), .y(lerp_pt.z));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pt <= load_pt;
    end else if (ctl.shift) begin
      pt <= lerp_pt;
    end
  end
endmodule

// ===== rtl/bezier_curve_point_eval.sv =====
// Bezier point evaluator, de Casteljau reduction over a row of MAX_POINTS
// cells. A load word writes one control point in the cycle it is accepted and
// the input stays ready for the next word. An evaluate word first copies the
// first point_count points (clamped to 1..MAX_POINTS) into the cell row,
// then runs one pass fewer than that clamped count, in each of which every
// cell lerps toward its right neighbor at once (the last cell toward itself),
// then captures cell 0 into the output register, where the result word waits
// until taken. The input is held off from the acceptance of an evaluate until
// its result is taken. Loads and evaluates are handled one at a time; the
// lerp in each cell bounds the clock.
// Slots never loaded read as undefined.
module bezier_curve_point_eval
  import bcpe_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input logic        clk,
  input logic        rst,
  bcpe_in_if.sink    in_ch,
  bcpe_out_if.source out_ch,
  bcpe_cfg_if.sink   cfg_ch
);
  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;
  logic [CountW-1:0] point_count;
  logic [CntW-1:0] passes;
  logic [RatioW-1:0] ratio_q;
  point_t store [MAX_POINTS];
  point_t cells [MAX_POINTS];
  point_t res;
  cell_ctl_t ctl;
  logic in_fire;
  logic [CntW-1:0] n_clamp;

  assign in_ch.ready  = (state == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.out_x = res.x;
  assign out_ch.out_y = res.y;
  assign out_ch.out_z = res.z;

  // clamp the count into 1..MAX_POINTS
  always_comb begin
    if (point_count == '0) begin
      n_clamp = CntW'(1);
    end else if (32'(point_count) > MAX_POINTS) begin
      n_clamp = CntW'(MAX_POINTS);
    end else begin
      n_clamp = CntW'(point_count);
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CountReset;
    end else if (cfg_ch.valid) begin
      point_count <= cfg_ch.data;
    end
  end

  // point store, loads only
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.command == CMD_LOAD
        && 32'(in_ch.point_index) < MAX_POINTS) begin
      store[IdxW'(in_ch.point_index)] <= '{x: in_ch.in_x, y: in_ch.in_y,
                                           z: in_ch.in_z};
    end
  end

  // cell row
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    point_t right;
    if (i == MAX_POINTS - 1) begin : g_last
      assign right = cells[i];
    end else begin : g_mid
      assign right = cells[i+1];
    end
    bcpe_cell u_cell (
      .clk(clk), .ctl(ctl), .load_pt(store[i]), .right_pt(right),
      .t(ratio_q), .pt(cells[i])
    );
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ratio_q <= (in_ch.ratio > RatioOne) ? RatioOne : in_ch.ratio;
    end
    if (state == ST_FILL) begin
      passes <= n_clamp - CntW'(1);
    end else if (state == ST_RUN) begin
      passes <= passes - CntW'(1);
    end
    if (state == ST_RUN && passes == '0) begin
      res <= cells[0];
    end
  end

  always_comb begin
    state_next = state;
    ctl = '{load: 1'b0, shift: 1'b0};
    case (state)
      ST_IDLE: begin
        if (in_fire && in_ch.command == CMD_EVAL) state_next = ST_FILL;
      end
      ST_FILL: begin
        ctl.load = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (passes == '0) begin
          state_next = ST_OUT;
        end else begin
          ctl.shift = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_no_accept_busy, clk, rst, state != ST_IDLE, !in_ch.ready)
  `ASSERT_NEXT(a_eval_fills, clk, rst, in_fire && in_ch.command == CMD_EVAL, state == ST_FILL)
  `ASSERT_IMPL(a_ctl_excl, clk, rst, 1'b1, !(ctl.load && ctl.shift))
endmodule

// ===== bench/tb_bezier_curve_point_eval.sv =====
`timescale 1ns / 1ps

module tb_bezier_curve_point_eval;
  import bcpe_pkg::*;

  localparam int NumPts = MaxPointsDef;

  // Input word as queued for the driver
  typedef struct {
    cmd_t              command;
    logic [3:0]        point_index;
    coord_t            x;
    coord_t            y;
    coord_t            z;
    logic [RatioW-1:0] ratio;
  } curve_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcpe_in_if  in_ch ();
  bcpe_out_if out_ch ();
  bcpe_cfg_if cfg_ch ();

  bezier_curve_point_eval u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  coord_t            ctl_x [NumPts];
  coord_t            ctl_y [NumPts];
  coord_t            ctl_z [NumPts];
  logic [CountW-1:0] count_reg;

  curve_word_t pending_words[$];
  point_t      expected_points[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int evals_seen = 0;
  int loads_sent = 0;

  // One axis of de Casteljau reduction, lerp with floor shift
  function automatic coord_t reduce_axis(input coord_t pts[NumPts], input int n,
                                         input logic [RatioW-1:0] t);
    longint p[NumPts];
    longint prod;
    for (int i = 0; i < n; i++) p[i] = longint'(pts[i]);
    for (int lv = n - 1; lv > 0; lv--)
      for (int i = 0; i < lv; i++) begin
        prod = longint'(t) * (p[i+1] - p[i]);
        p[i] = p[i] + (prod >>> 16);
      end
    return coord_t'(p[0]);
  endfunction

  function automatic point_t curve_point(input logic [RatioW-1:0] r);
    int n;
    logic [RatioW-1:0] t;
    point_t pt;
    n = (count_reg == 0) ? 1 : ((count_reg > NumPts) ? NumPts : int'(count_reg));
    t = (r > RatioOne) ? RatioOne : r;
    pt.x = reduce_axis(ctl_x, n, t);
    pt.y = reduce_axis(ctl_y, n, t);
    pt.z = reduce_axis(ctl_z, n, t);
    return pt;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return coord_t'($urandom_range(0, 2000)) - 1000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [RatioW-1:0] rand_ratio();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return RatioOne;
      2: return RatioW'($urandom_range(65537, 131071));
      default: return RatioW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic curve_word_t load_word(input int idx);
    curve_word_t w;
    w.command = CMD_LOAD;
    w.point_index = 4'(idx);
    w.x = rand_coord();
    w.y = rand_coord();
    w.z = rand_coord();
    w.ratio = RatioW'($urandom);
    return w;
  endfunction

  function automatic curve_word_t eval_word(input logic [RatioW-1:0] r);
    curve_word_t w;
    w.command = CMD_EVAL;
    w.point_index = 4'($urandom);
    w.x = coord_t'($urandom);
    w.y = coord_t'($urandom);
    w.z = coord_t'($urandom);
    w.ratio = r;
    return w;
  endfunction

  // Driver: feeds queued words, with random idle cycles
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.command <= CMD_LOAD;
      in_ch.point_index <= '0;
      in_ch.in_x <= '0;
      in_ch.in_y <= '0;
      in_ch.in_z <= '0;
      in_ch.ratio <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        curve_word_t w;
        w = pending_words.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.command <= w.command;
        in_ch.point_index <= w.point_index;
        in_ch.in_x <= w.x;
        in_ch.in_y <= w.y;
        in_ch.in_z <= w.z;
        in_ch.ratio <= w.ratio;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      if (in_ch.command == CMD_LOAD) begin
        ctl_x[in_ch.point_index] = in_ch.in_x;
        ctl_y[in_ch.point_index] = in_ch.in_y;
        ctl_z[in_ch.point_index] = in_ch.in_z;
        loads_sent++;
      end else begin
        expected_points = {expected_points, curve_point(in_ch.ratio)};
      end
    end
  end

  // Monitor: random back-pressure and result checks
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        evals_seen++;
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                   out_ch.out_x, out_ch.out_y, out_ch.out_z);
        end else begin
          point_t e;
          e = expected_points.pop_front();
          if (out_ch.out_x !== e.x) begin
            errors++;
            $display("%0t: out_x expected %h actual %h", $time, e.x, out_ch.out_x);
          end
          if (out_ch.out_y !== e.y) begin
            errors++;
            $display("%0t: out_y expected %h actual %h", $time, e.y, out_ch.out_y);
          end
          if (out_ch.out_z !== e.z) begin
            errors++;
            $display("%0t: out_z expected %h actual %h", $time, e.z, out_ch.out_z);
          end
        end
      end
    end
  end

  task automatic queue_word(input curve_word_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_ch.valid || expected_points.size() > 0)
      @(posedge clk);
    // trailing loads give no result; let them finish
    repeat (NumPts + 4) @(posedge clk);
  endtask

  task automatic write_count(input logic [CountW-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    count_reg = v;
  endtask

  // Random words: mostly evaluates over loaded slots, some loads
  task automatic queue_random(input int num);
    for (int k = 0; k < num; k++)
      if ($urandom_range(0, 2) == 0) queue_word(load_word($urandom_range(0, 15)));
      else queue_word(eval_word(rand_ratio()));
  endtask

  initial begin
    logic [CountW-1:0] counts[6];
    int idle_s[4];
    int idle_r[4];
    counts = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd7};
    idle_s = '{0, 55, 0, 7};
    idle_r = '{0, 0, 55, 7};
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    count_reg = CountReset;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill all slots, extremes and reset count
    for (int i = 0; i < NumPts; i++) queue_word(load_word(i));
    queue_word(eval_word('0));
    queue_word(eval_word(RatioOne));
    queue_word(eval_word('1));
    queue_word(eval_word(17'h08000));
    wait_drained();

    // Phases over point counts and idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      write_count(counts[ph]);
      for (int s = 0; s < 4; s++) begin
        send_idle_pct = idle_s[s];
        recv_stall_pct = idle_r[s];
        queue_random(75);
        if (s == 1) begin
          // hold off until all results are in
          while (pending_words.size() > 0 || in_ch.valid || expected_points.size() > 0)
            @(posedge clk);
          queue_random(5);
        end
        wait_drained();
      end
    end
    $display("Covered %0d loads and %0d evaluates over point counts 0..31 (clamped)",
             loads_sent, evals_seen);
    $display("with sender idling and receiver stalls mixed in");
    if (errors == 0) begin
      $display("tb_bezier_curve_point_eval OK");
    end else begin
      $display("tb_bezier_curve_point_eval NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("tb_bezier_curve_point_eval NOT OK");
    $finish;
  end
endmodule
